### hdl/lpfs_pkg.sv
`default_nettype none

package lpfs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned KindW  = 2;
  localparam int unsigned SeenW  = 31;

  // result kind codes
  localparam logic [KindW-1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [KindW-1:0] KIND_EMPTY     = 2'd1;
  localparam logic [KindW-1:0] KIND_MALFORMED = 2'd2;

  typedef struct packed {
    logic signed [WordW-1:0] msg_id;
    logic [ByteW-1:0]        payload_byte;
    logic [KindW-1:0]        kind;
    logic                    last;
  } result_t;

endpackage

`default_nettype wire

### hdl/lpfs_rx_if.sv
`default_nettype none

interface lpfs_rx_if;
  logic                          valid;
  logic                          ready;
  logic [lpfs_pkg::ByteW-1:0]    rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### hdl/lpfs_res_if.sv
`default_nettype none

interface lpfs_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [lpfs_pkg::WordW-1:0]  msg_id;
  logic [lpfs_pkg::ByteW-1:0]         payload_byte;
  logic [lpfs_pkg::KindW-1:0]         kind;
  logic                               last;

  modport source (output valid, output msg_id, output payload_byte, output kind,
                  output last, input ready);
  modport sink   (input valid, input msg_id, input payload_byte, input kind,
                  input last, output ready);
endinterface

`default_nettype wire

### hdl/lpfs_parser.sv
`default_nettype none

module lpfs_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [lpfs_pkg::ByteW-1:0]    rx_byte_i,
  input  wire logic                          res_ready_i,
  output logic                               res_valid_o,
  output lpfs_pkg::result_t                  res_o
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_ID,
    PH_PAYLOAD,
    PH_SKIP
  } phase_e;

  phase_e                          phase_q, phase_d;
  logic [1:0]                      hdr_cnt_q, hdr_cnt_d;
  logic [lpfs_pkg::WordW-1:0]      frame_len_q, frame_len_d;
  logic [lpfs_pkg::WordW-1:0]      id_q, id_d;
  logic [lpfs_pkg::SeenW-1:0]      seen_q, seen_d;
  logic                            res_valid_q, res_valid_d;
  lpfs_pkg::result_t               res_q, res_d;

  logic [lpfs_pkg::WordW-1:0]      len_asm;
  logic [lpfs_pkg::WordW-1:0]      id_asm;
  logic [lpfs_pkg::SeenW-1:0]      seen_inc;
  logic [lpfs_pkg::WordW-1:0]      seen_inc_w;
  logic                            emit;
  lpfs_pkg::result_t               res_new;

  // little-endian byte lanes, lanes above the count are still zero
  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign len_asm[8*k +: 8] = (hdr_cnt_q == 2'(k)) ? rx_byte_i :
                               (hdr_cnt_q == 2'd0) ? 8'd0 : frame_len_q[8*k +: 8];
    assign id_asm[8*k +: 8]  = (seen_q[1:0] == 2'(k)) ? rx_byte_i : id_q[8*k +: 8];
  end

  assign seen_inc   = seen_q + 31'd1;
  assign seen_inc_w = {1'b0, seen_inc};

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    frame_len_d = frame_len_q;
    id_d        = id_q;
    seen_d      = seen_q;
    emit        = 1'b0;
    res_new     = '0;
    unique case (phase_q)
      PH_HEADER: begin
        frame_len_d = len_asm;
        hdr_cnt_d   = hdr_cnt_q + 2'd1;
        if (hdr_cnt_q == 2'd3) begin
          seen_d = '0;
          if (len_asm[31] || (len_asm == '0)) begin
            // negative or zero length: drop header
            phase_d = PH_HEADER;
          end else if (len_asm < 32'd4) begin
            phase_d      = PH_SKIP;
            emit         = 1'b1;
            res_new.kind = lpfs_pkg::KIND_MALFORMED;
            res_new.last = 1'b1;
          end else begin
            id_d    = '0;
            phase_d = PH_ID;
          end
        end
      end
      PH_ID: begin
        id_d   = id_asm;
        seen_d = seen_inc;
        if (seen_inc == 31'd4) begin
          if (frame_len_q == 32'd4) begin
            phase_d        = PH_HEADER;
            emit           = 1'b1;
            res_new.msg_id = id_asm;
            res_new.kind   = lpfs_pkg::KIND_EMPTY;
            res_new.last   = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        seen_d               = seen_inc;
        emit                 = 1'b1;
        res_new.msg_id       = id_q;
        res_new.payload_byte = rx_byte_i;
        res_new.kind         = lpfs_pkg::KIND_PAYLOAD;
        res_new.last         = (seen_inc_w == frame_len_q);
        if (seen_inc_w == frame_len_q) begin
          phase_d = PH_HEADER;
        end
      end
      PH_SKIP: begin
        seen_d = seen_inc;
        if (seen_inc_w >= frame_len_q) begin
          phase_d = PH_HEADER;
        end
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase
  end

  always_comb begin
    res_d = res_q;
    if (step_i && emit) begin
      res_valid_d = 1'b1;
      res_d       = res_new;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= '0;
      frame_len_q <= '0;
      id_q        <= '0;
      seen_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (step_i) begin
        phase_q     <= phase_d;
        hdr_cnt_q   <= hdr_cnt_d;
        frame_len_q <= frame_len_d;
        id_q        <= id_d;
        seen_q      <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### hdl/length_prefixed_frame_splitter_top.sv
// Length-prefixed frame splitter. Takes a byte stream, one byte per item on rx_i, where each
// frame is a 4-byte little-endian signed length L followed by L bytes: a 4-byte
// little-endian message id and L-4 payload bytes. Every payload byte comes out on res_o
// with its id and kind payload, last set on the final byte of the frame; a frame with no
// payload gives one empty-message item with last set. A negative or zero length header is
// dropped silently and the next four bytes form a new header. A length of 1 to 3 gives one
// malformed item (id and byte zero, last set) and the L body bytes are then skipped.
// Each byte passes an input register and a result register, so one byte is taken every
// cycle while res_o is not stalled. Stalls on res_o back up to rx_i through the input
// register; nothing is dropped.
`default_nettype none

module length_prefixed_frame_splitter_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lpfs_rx_if.sink     rx_i,
  lpfs_res_if.source  res_o
);

  // input register
  logic                         in_valid_q, in_valid_d;
  logic [lpfs_pkg::ByteW-1:0]   in_byte_q;
  logic                         rx_take;
  logic                         adv;
  logic                         res_valid;
  lpfs_pkg::result_t            res;

  // the registered byte moves on when the result register is free or draining
  assign adv      = in_valid_q && (!res_valid || res_o.ready);
  assign rx_i.ready = !in_valid_q || adv;
  assign rx_take  = rx_i.valid && rx_i.ready;

  always_comb begin
    if (rx_take) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // frame state and result register
  lpfs_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .rx_byte_i   (in_byte_q),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign res_o.valid        = res_valid;
  assign res_o.msg_id       = res.msg_id;
  assign res_o.payload_byte = res.payload_byte;
  assign res_o.kind         = res.kind;
  assign res_o.last         = res.last;

  // malformed items carry no id and always close the frame
  a_malformed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res.kind == lpfs_pkg::KIND_MALFORMED) |->
      (res.msg_id == 0) && res.last)
    else $error("malformed item with id or without last");

  // non-payload items carry a zero byte and end the frame
  a_nonpayload_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && (res.kind != lpfs_pkg::KIND_PAYLOAD) |->
      (res.payload_byte == 0) && res.last)
    else $error("non-payload item with byte or without last");

  // a byte waiting in the input register is kept while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> in_valid_q && $stable(in_byte_q))
    else $error("input byte lost during stall");

endmodule

`default_nettype wire
